>>> rtl/jsu_pkg.sv
// shared types and codes for the json string unescaper
package jsu_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueueAw    = $clog2(QueueDepth);

    localparam logic [15:0] MaxLengthReset = 16'd256;

    localparam logic [0:0] RegMaxLength = 1'b0;

    localparam logic [2:0] ErrNone        = 3'd0;
    localparam logic [2:0] ErrExpString   = 3'd1;
    localparam logic [2:0] ErrTruncEscape = 3'd2;
    localparam logic [2:0] ErrBadEscape   = 3'd3;
    localparam logic [2:0] ErrTruncUni    = 3'd4;
    localparam logic [2:0] ErrBadUni      = 3'd5;
    localparam logic [2:0] ErrTooLong     = 3'd6;
    localparam logic [2:0] ErrUnterm      = 3'd7;

    // one decoded character (1..3 bytes) or one control word
    typedef struct packed {
        logic       chr;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] cnt;
        logic       done;
        logic [2:0] err;
    } t_rec;

    typedef struct packed {
        logic push;
        t_rec rec;
    } t_push;

endpackage

>>> rtl/jsu_if.sv
// valid/ready channels for raw input and decoded output words
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;
    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] error_code;
    logic       last;
    modport source (output valid, output out_byte, output byte_valid, output string_done,
                    output error_code, output last, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input string_done,
                  input error_code, input last, output ready);
endinterface

>>> rtl/jsu_front.sv
// front end: scans raw bytes, decodes escapes and checks the length bound
module jsu_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    jsu_in_if.sink         i_src,
    input  logic [15:0]    i_max_length,
    input  logic           i_full,
    output jsu_pkg::t_push o_push
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_BODY = 5'b00010,
        ST_ESC  = 5'b00100,
        ST_HEX  = 5'b01000,
        ST_ERR  = 5'b10000
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [2:0]  r_hex_count, n_hex_count;
    logic [15:0] r_code_point, n_code_point;
    logic        r_hex_bad, n_hex_bad;
    logic [16:0] r_len, n_len;

    logic        accept;
    logic [7:0]  c;
    logic        fin;
    logic        is_hex;
    logic [3:0]  hex_d;
    logic [15:0] cp;
    logic        emit;
    logic [1:0]  emit_n;
    logic [7:0]  eb0, eb1, eb2;
    logic [16:0] nl;

    assign i_src.ready = !i_full;
    assign accept      = i_src.valid && !i_full;
    assign c           = i_src.in_byte;
    assign fin         = i_src.stream_end;

    always_comb begin
        is_hex = 1'b1;
        hex_d  = 4'd0;
        case (c) inside
            [8'h30:8'h39]: hex_d = c[3:0];
            [8'h41:8'h46], [8'h61:8'h66]: hex_d = c[3:0] + 4'd9;
            default: is_hex = 1'b0;
        endcase
    end

    assign cp = {r_code_point[11:0], hex_d};
    assign nl = r_len + {15'd0, emit_n};

    always_comb begin
        n_mode       = r_mode;
        n_hex_count  = r_hex_count;
        n_code_point = r_code_point;
        n_hex_bad    = r_hex_bad;
        n_len        = r_len;
        o_push       = '0;
        emit         = 1'b0;
        emit_n       = 2'd1;
        eb0          = c;
        eb1          = 8'd0;
        eb2          = 8'd0;
        if (accept) begin
            case (r_mode)
                ST_IDLE: begin
                    if (fin) begin
                        o_push.push    = 1'b1;
                        o_push.rec.err = jsu_pkg::ErrExpString;
                        n_mode         = ST_ERR;
                    end else if (c == 8'h22) begin
                        n_mode = ST_BODY;
                        n_len  = '0;
                    end else if (!(c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D)) begin
                        o_push.push    = 1'b1;
                        o_push.rec.err = jsu_pkg::ErrExpString;
                        n_mode         = ST_ERR;
                    end
                end
                ST_BODY: begin
                    if (fin) begin
                        o_push.push    = 1'b1;
                        o_push.rec.err = jsu_pkg::ErrUnterm;
                        n_mode         = ST_ERR;
                    end else if (c == 8'h22) begin
                        o_push.push     = 1'b1;
                        o_push.rec.done = 1'b1;
                        n_mode          = ST_IDLE;
                    end else if (c == 8'h5C) begin
                        n_mode = ST_ESC;
                    end else begin
                        emit = 1'b1;
                    end
                end
                ST_ESC: begin
                    if (fin) begin
                        o_push.push    = 1'b1;
                        o_push.rec.err = jsu_pkg::ErrTruncEscape;
                        n_mode         = ST_ERR;
                    end else begin
                        emit   = 1'b1;
                        n_mode = ST_BODY;
                        case (c)
                            8'h22, 8'h5C, 8'h2F: eb0 = c;
                            8'h62: eb0 = 8'h08;
                            8'h66: eb0 = 8'h0C;
                            8'h6E: eb0 = 8'h0A;
                            8'h72: eb0 = 8'h0D;
                            8'h74: eb0 = 8'h09;
                            8'h75: begin
                                emit         = 1'b0;
                                n_mode       = ST_HEX;
                                n_hex_count  = '0;
                                n_code_point = '0;
                                n_hex_bad    = 1'b0;
                            end
                            default: begin
                                emit           = 1'b0;
                                o_push.push    = 1'b1;
                                o_push.rec.err = jsu_pkg::ErrBadEscape;
                                n_mode         = ST_ERR;
                            end
                        endcase
                    end
                end
                ST_HEX: begin
                    if (fin) begin
                        o_push.push    = 1'b1;
                        o_push.rec.err = jsu_pkg::ErrTruncUni;
                        n_mode         = ST_ERR;
                    end else begin
                        if (is_hex) begin
                            n_code_point = cp;
                        end else begin
                            n_hex_bad = 1'b1;
                        end
                        n_hex_count = r_hex_count + 3'd1;
                        if (r_hex_count == 3'd3) begin
                            if (r_hex_bad || !is_hex) begin
                                o_push.push    = 1'b1;
                                o_push.rec.err = jsu_pkg::ErrBadUni;
                                n_mode         = ST_ERR;
                            end else begin
                                emit   = 1'b1;
                                n_mode = ST_BODY;
                                // utf-8 split by code point range
                                if (cp[15:7] == '0) begin
                                    eb0 = {1'b0, cp[6:0]};
                                end else if (cp[15:11] == '0) begin
                                    emit_n = 2'd2;
                                    eb0    = {3'b110, cp[10:6]};
                                    eb1    = {2'b10, cp[5:0]};
                                end else begin
                                    emit_n = 2'd3;
                                    eb0    = {4'b1110, cp[15:12]};
                                    eb1    = {2'b10, cp[11:6]};
                                    eb2    = {2'b10, cp[5:0]};
                                end
                            end
                        end
                    end
                end
                default: n_mode = ST_ERR;
            endcase

            if (emit) begin
                o_push.push = 1'b1;
                if (nl > {1'b0, i_max_length}) begin
                    o_push.rec.err = jsu_pkg::ErrTooLong;
                    n_mode         = ST_ERR;
                end else begin
                    n_len          = nl;
                    o_push.rec.chr = 1'b1;
                    o_push.rec.b0  = eb0;
                    o_push.rec.b1  = eb1;
                    o_push.rec.b2  = eb2;
                    o_push.rec.cnt = emit_n;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= ST_IDLE;
            r_hex_count  <= '0;
            r_code_point <= '0;
            r_hex_bad    <= 1'b0;
            r_len        <= '0;
        end else begin
            r_mode       <= n_mode;
            r_hex_count  <= n_hex_count;
            r_code_point <= n_code_point;
            r_hex_bad    <= n_hex_bad;
            r_len        <= n_len;
        end
    end

endmodule

>>> rtl/jsu_fifo.sv
// short queue of decoded characters between front and back end
module jsu_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  jsu_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output jsu_pkg::t_rec  o_head
);

    localparam int unsigned Aw = jsu_pkg::QueueAw;

    jsu_pkg::t_rec r_mem [jsu_pkg::QueueDepth];
    logic [Aw:0]   r_wp, n_wp;
    logic [Aw:0]   r_rp, n_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[Aw] != r_rp[Aw]) && (r_wp[Aw-1:0] == r_rp[Aw-1:0]);
    assign o_head  = r_mem[r_rp[Aw-1:0]];

    assign n_wp = r_wp + {{Aw{1'b0}}, (i_push.push && !o_full)};
    assign n_rp = r_rp + {{Aw{1'b0}}, (i_pop && !o_empty)};

    always_ff @(posedge i_clk) begin
        if (i_push.push && !o_full) begin
            r_mem[r_wp[Aw-1:0]] <= i_push.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

endmodule

>>> rtl/jsu_back.sv
// back end: splits queued characters into output words behind a register
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  jsu_pkg::t_rec i_head,
    output logic          o_pop,
    jsu_out_if.source     o_dst
);

    logic       r_valid, n_valid;
    logic [1:0] r_idx, n_idx;
    logic [7:0] r_byte;
    logic       r_byte_valid;
    logic       r_done;
    logic [2:0] r_err;
    logic       r_last;

    logic       load;
    logic       head_last;
    logic [7:0] head_byte;

    assign load      = !i_empty && (!r_valid || o_dst.ready);
    assign head_last = !i_head.chr || (r_idx == i_head.cnt - 2'd1);
    assign o_pop     = load && head_last;

    always_comb begin
        case (r_idx)
            2'd0:    head_byte = i_head.b0;
            2'd1:    head_byte = i_head.b1;
            default: head_byte = i_head.b2;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = head_last ? 2'd0 : r_idx + 2'd1;
        end else if (o_dst.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte       <= i_head.chr ? head_byte : 8'd0;
            r_byte_valid <= i_head.chr;
            r_done       <= i_head.done;
            r_err        <= i_head.err;
            r_last       <= head_last;
        end
    end

    assign o_dst.valid       = r_valid;
    assign o_dst.out_byte    = r_byte;
    assign o_dst.byte_valid  = r_byte_valid;
    assign o_dst.string_done = r_done;
    assign o_dst.error_code  = r_err;
    assign o_dst.last        = r_last;

endmodule

>>> rtl/json_string_unescape.sv
// top level of the json string unescaper
// Takes one raw byte of a JSON string literal per cycle and returns the decoded
// string one output word per byte, with closing-quote and error words marked;
// errors are sticky until reset. Input bytes are taken every cycle while the
// four-entry character queue has room; the output side gives one word per cycle
// while o_dst.ready is high, so a \u escape that becomes two or three UTF-8 bytes
// holds the output longer, and the queue absorbs the difference. max_length sits
// at byte address 0 and resets to 256.
module json_string_unescape (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jsu_in_if.sink      i_src,
    jsu_out_if.source   o_dst,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]    r_max_length;
    jsu_pkg::t_push push;
    jsu_pkg::t_rec  head;
    logic           full;
    logic           empty;
    logic           pop;
    logic           reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2:2] == jsu_pkg::RegMaxLength);
    assign prdata  = reg_hit ? {16'd0, r_max_length} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= jsu_pkg::MaxLengthReset;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_max_length <= pwdata[15:0];
        end
    end

    jsu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_src        (i_src),
        .i_max_length (r_max_length),
        .i_full       (full),
        .o_push       (push)
    );

    jsu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_dst   (o_dst)
    );

    // a decoded byte word never carries a status
    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dst.valid && o_dst.byte_valid |-> !o_dst.string_done
            && o_dst.error_code == jsu_pkg::ErrNone)
        else $error("byte word carries status");

    // status words close their character
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dst.valid && !o_dst.byte_valid |-> o_dst.last)
        else $error("status word not last");

    // nothing follows an error word
    a_err_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dst.valid && o_dst.ready && o_dst.error_code != jsu_pkg::ErrNone
            |=> !o_dst.valid)
        else $error("word after error");

    // queue never gets a word while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !(i_src.valid && i_src.ready))
        else $error("input taken with queue full");

endmodule

>>> tb/sv/json_string_unescape_checker.sv
// checker for the json string unescaper: predicts decoded words and compares them
`timescale 1ns / 1ps
module json_string_unescape_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jsu_in_if           i_src,
    jsu_out_if          i_dst,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    localparam logic [2:0] MaxLenAddr = {jsu_pkg::RegMaxLength, 2'b00};

    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChB      = 8'h62;
    localparam logic [7:0] ChF      = 8'h66;
    localparam logic [7:0] ChN      = 8'h6E;
    localparam logic [7:0] ChR      = 8'h72;
    localparam logic [7:0] ChT      = 8'h74;
    localparam logic [7:0] ChU      = 8'h75;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChCr     = 8'h0D;

    typedef enum logic [2:0] {ScanIdle, ScanBody, ScanEscape, ScanHex, ScanHalted} t_scan;

    typedef struct packed {
        logic [7:0] data;
        logic       is_byte;
        logic       done;
        logic [2:0] err;
        logic       lst;
    } t_word;

    t_scan       scan;
    logic [2:0]  hex_seen;
    logic [15:0] code_pt;
    logic        hex_bad;
    logic [16:0] str_len;
    logic [15:0] len_bound;
    t_word       expected_words[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic void push_word(logic [7:0] data, logic is_byte, logic done,
                                      logic [2:0] err, logic lst);
        t_word w;
        w.data    = data;
        w.is_byte = is_byte;
        w.done    = done;
        w.err     = err;
        w.lst     = lst;
        expected_words.insert(expected_words.size(), w);
    endfunction

    // errors are sticky: the scanner stays halted until reset
    function automatic void halt(logic [2:0] code);
        scan = ScanHalted;
        push_word(8'h00, 1'b0, 1'b0, code, 1'b1);
    endfunction

    // one decoded character of n bytes, left aligned in seq
    function automatic void add_char(logic [23:0] seq, int n);
        int k;
        if (int'(str_len) + n > int'(len_bound)) begin
            halt(jsu_pkg::ErrTooLong);
        end else begin
            str_len = str_len + 17'(n);
            for (k = 0; k < n; k++)
                push_word(seq[23 - 8*k -: 8], 1'b1, 1'b0, jsu_pkg::ErrNone, k == n - 1);
        end
    endfunction

    function automatic int hex_val(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 'h30;
        if (c >= "a" && c <= "f") return int'(c) - 'h61 + 10;
        if (c >= "A" && c <= "F") return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic void take_byte(logic [7:0] c, logic fin);
        int d;
        case (scan)
            ScanIdle: begin
                if (fin) halt(jsu_pkg::ErrExpString);
                else if (c == ChSpace || c == ChTab || c == ChLf || c == ChCr) ;
                else if (c != ChQuote) halt(jsu_pkg::ErrExpString);
                else begin
                    scan    = ScanBody;
                    str_len = '0;
                end
            end
            ScanBody: begin
                if (fin) halt(jsu_pkg::ErrUnterm);
                else if (c == ChQuote) begin
                    scan = ScanIdle;
                    push_word(8'h00, 1'b0, 1'b1, jsu_pkg::ErrNone, 1'b1);
                end else if (c == ChBslash) scan = ScanEscape;
                else add_char({c, 16'h0}, 1);
            end
            ScanEscape: begin
                if (fin) halt(jsu_pkg::ErrTruncEscape);
                else if (c == ChU) begin
                    scan     = ScanHex;
                    hex_seen = '0;
                    code_pt  = '0;
                    hex_bad  = 1'b0;
                end else begin
                    scan = ScanBody;
                    case (c)
                        ChQuote:  add_char({8'h22, 16'h0}, 1);
                        ChBslash: add_char({8'h5C, 16'h0}, 1);
                        ChSlash:  add_char({8'h2F, 16'h0}, 1);
                        ChB:      add_char({8'h08, 16'h0}, 1);
                        ChF:      add_char({8'h0C, 16'h0}, 1);
                        ChN:      add_char({8'h0A, 16'h0}, 1);
                        ChR:      add_char({8'h0D, 16'h0}, 1);
                        ChT:      add_char({8'h09, 16'h0}, 1);
                        default:  halt(jsu_pkg::ErrBadEscape);
                    endcase
                end
            end
            ScanHex: begin
                if (fin) halt(jsu_pkg::ErrTruncUni);
                else begin
                    d = hex_val(c);
                    if (d < 0) hex_bad = 1'b1;
                    else code_pt = {code_pt[11:0], 4'(d)};
                    hex_seen = hex_seen + 3'd1;
                    // a bad digit only shows once the fourth one is in
                    if (hex_seen == 3'd4) begin
                        if (hex_bad) halt(jsu_pkg::ErrBadUni);
                        else begin
                            scan = ScanBody;
                            if (code_pt < 16'h0080)
                                add_char({code_pt[7:0], 16'h0}, 1);
                            else if (code_pt < 16'h0800)
                                add_char({3'b110, code_pt[10:6], 2'b10, code_pt[5:0], 8'h0}, 2);
                            else
                                add_char({4'b1110, code_pt[15:12], 2'b10, code_pt[11:6],
                                          2'b10, code_pt[5:0]}, 3);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            scan      = ScanIdle;
            hex_seen  = '0;
            code_pt   = '0;
            hex_bad   = 1'b0;
            str_len   = '0;
            len_bound = jsu_pkg::MaxLengthReset;
            expected_words.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == MaxLenAddr)
                len_bound = i_pwdata[15:0];
            if (i_src.valid && i_src.ready)
                take_byte(i_src.in_byte, i_src.stream_end);
            if (i_dst.valid && i_dst.ready) begin
                if (expected_words.size() == 0) begin
                    $error("word with nothing expected: out_byte %0h byte_valid %0b err %0d",
                           i_dst.out_byte, i_dst.byte_valid, i_dst.error_code);
                    o_fail_count++;
                end else begin
                    w = expected_words.pop_front();
                    check_field("out_byte", w.data, i_dst.out_byte);
                    check_field("byte_valid", w.is_byte, i_dst.byte_valid);
                    check_field("string_done", w.done, i_dst.string_done);
                    check_field("error_code", w.err, i_dst.error_code);
                    check_field("last", w.lst, i_dst.last);
                    o_checked++;
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

>>> tb/sv/json_string_unescape_test.sv
// top of the json string unescaper testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module json_string_unescape_test;

    localparam int IdleLimit = 2000;
    localparam logic [2:0] MaxLenAddr = {jsu_pkg::RegMaxLength, 2'b00};

    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChB      = 8'h62;
    localparam logic [7:0] ChF      = 8'h66;
    localparam logic [7:0] ChN      = 8'h6E;
    localparam logic [7:0] ChR      = 8'h72;
    localparam logic [7:0] ChT      = 8'h74;
    localparam logic [7:0] ChU      = 8'h75;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChCr     = 8'h0D;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    jsu_in_if  src_ch ();
    jsu_out_if dst_ch ();

    int         fail_count;
    int         words_pending;
    int         words_checked;
    int         bytes_sent   = 0;
    int         reg_writes   = 0;
    int         max_len_now  = 256;
    int         idle_cycles  = 0;
    int         out_hold     = 0;
    int         out_calm     = 0;
    bit         in_calm      = 1'b0;
    logic [2:0] final_err;

    json_string_unescape i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_src   (src_ch),
        .o_dst   (dst_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    json_string_unescape_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_src        (src_ch),
        .i_dst        (dst_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (words_pending),
        .o_checked    (words_checked)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] esc_letter(int k);
        case (k)
            0:       return ChQuote;
            1:       return ChBslash;
            2:       return ChSlash;
            3:       return ChB;
            4:       return ChF;
            5:       return ChN;
            6:       return ChR;
            default: return ChT;
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == ChQuote || b == ChBslash);
        return b;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
    endfunction

    // code point whose utf-8 form takes sz bytes, edges of the range favoured
    function automatic logic [15:0] code_for(int sz);
        logic [15:0] lo;
        logic [15:0] hi;
        int          pick;
        lo   = (sz == 1) ? 16'h0000 : (sz == 2) ? 16'h0080 : 16'h0800;
        hi   = (sz == 1) ? 16'h007F : (sz == 2) ? 16'h07FF : 16'hFFFF;
        pick = $urandom_range(0, 7);
        if (pick == 0) return lo;
        if (pick == 1) return hi;
        if (pick == 2 && sz == 3) return 16'($urandom_range(16'hD800, 16'hDFFF));
        return 16'($urandom_range(lo, hi));
    endfunction

    task automatic send_raw(input logic [7:0] b, input logic fin);
        int gap;
        gap = in_calm ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            src_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_ch.valid      = 1'b1;
        src_ch.in_byte    = b;
        src_ch.stream_end = fin;
        do @(posedge clk); while (!src_ch.ready);
        bytes_sent++;
    endtask

    task automatic end_burst();
        @(negedge clk);
        src_ch.valid = 1'b0;
    endtask

    task automatic cfg_write(input logic [15:0] value);
        end_burst();
        do @(negedge clk); while (words_pending != 0);
        // quote and whitespace words leave nothing to wait for, so let the pipe drain
        repeat (8) @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = MaxLenAddr;
        pwdata  = {16'h0, value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        max_len_now = value;
        reg_writes++;
    endtask

    // backslash u and ndig digits; the digit at bad_at is replaced by a non-hex byte
    task automatic send_uni(input logic [15:0] cp, input int ndig, input int bad_at);
        int         i;
        logic [7:0] b;
        send_raw(ChBslash, 1'b0);
        send_raw(ChU, 1'b0);
        for (i = 0; i < ndig; i++) begin
            if (i == bad_at) begin
                do b = 8'($urandom_range(0, 255));
                while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
                       (b >= "A" && b <= "F"));
            end else begin
                b = hex_char(cp[15 - 4*i -: 4]);
            end
            send_raw(b, 1'b0);
        end
    endtask

    // one decoded character that fits in room bytes
    task automatic send_piece(inout int room);
        int kind;
        int sz;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            send_raw(plain_byte(), 1'b0);
            room--;
        end else if (kind < 7) begin
            send_raw(ChBslash, 1'b0);
            send_raw(esc_letter($urandom_range(0, 7)), 1'b0);
            room--;
        end else begin
            sz = $urandom_range(1, (room < 3) ? room : 3);
            send_uni(code_for(sz), 4, -1);
            room -= sz;
        end
    endtask

    task automatic send_string();
        int cap;
        int room;
        int k;
        in_calm = ($urandom_range(0, 3) == 0);
        for (k = $urandom_range(0, 2); k > 0; k--)
            send_raw(esc_letter(0) == ChQuote ? (($urandom_range(0, 1)) ?
                     (($urandom_range(0, 1)) ? ChSpace : ChTab) :
                     (($urandom_range(0, 1)) ? ChLf : ChCr)) : ChSpace, 1'b0);
        send_raw(ChQuote, 1'b0);
        cap  = (max_len_now < 12) ? max_len_now : 12;
        // now and then fill the string right up to the bound
        room = (max_len_now <= 40 && $urandom_range(0, 5) == 0) ?
               max_len_now : $urandom_range(0, cap);
        while (room > 0) send_piece(room);
        send_raw(ChQuote, 1'b0);
        in_calm = 1'b0;
    endtask

    task automatic run_strings(input int target);
        while (bytes_sent < target) send_string();
    endtask

    // the block halts on its first error, so only one error ends the run
    task automatic send_failure();
        int         room;
        int         k;
        logic [7:0] b;
        bit         hit;
        final_err = 3'($urandom_range(1, 7));
        case (final_err)
            jsu_pkg::ErrExpString: begin
                if ($urandom_range(0, 1)) begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == ChQuote || b == ChSpace || b == ChTab || b == ChLf || b == ChCr);
                    send_raw(b, 1'b0);
                end else begin
                    send_raw(8'($urandom_range(0, 255)), 1'b1);
                end
            end
            jsu_pkg::ErrTruncEscape, jsu_pkg::ErrUnterm: begin
                send_raw(ChQuote, 1'b0);
                room = $urandom_range(0, (max_len_now < 4) ? max_len_now : 4);
                while (room > 0) send_piece(room);
                if (final_err == jsu_pkg::ErrTruncEscape) send_raw(ChBslash, 1'b0);
                send_raw(8'($urandom_range(0, 255)), 1'b1);
            end
            jsu_pkg::ErrBadEscape: begin
                send_raw(ChQuote, 1'b0);
                send_raw(ChBslash, 1'b0);
                do begin
                    b   = 8'($urandom_range(0, 255));
                    hit = (b == ChU);
                    for (k = 0; k < 8; k++)
                        if (b == esc_letter(k)) hit = 1'b1;
                end while (hit);
                send_raw(b, 1'b0);
            end
            jsu_pkg::ErrTruncUni: begin
                send_raw(ChQuote, 1'b0);
                send_uni(code_for($urandom_range(1, 3)), $urandom_range(0, 3),
                         $urandom_range(0, 4));
                send_raw(8'($urandom_range(0, 255)), 1'b1);
            end
            jsu_pkg::ErrBadUni: begin
                send_raw(ChQuote, 1'b0);
                send_uni(code_for($urandom_range(1, 3)), 4, $urandom_range(0, 3));
            end
            default: begin
                // too long: fill close to the bound, then a character that does not fit
                send_raw(ChQuote, 1'b0);
                room = max_len_now;
                while (room >= 3) send_piece(room);
                if (room == 0) send_raw(plain_byte(), 1'b0);
                else send_uni(code_for($urandom_range(room + 1, 3)), 4, -1);
            end
        endcase
        // the halted block swallows these
        for (k = 0; k < 4; k++)
            send_raw(8'($urandom_range(0, 255)), 1'(k % 2));
    endtask

    // output side: random stalls with calm stretches
    initial begin
        dst_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (out_hold > 0) begin
                out_hold--;
                dst_ch.ready = 1'b0;
            end else begin
                dst_ch.ready = 1'b1;
                if (out_calm > 0) out_calm--;
                else if ($urandom_range(0, 19) == 0) out_calm = $urandom_range(20, 80);
                else out_hold = pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        if ((src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("watchdog: no word moved for %0d cycles", IdleLimit);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int k;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        src_ch.valid      = 1'b0;
        src_ch.in_byte    = '0;
        src_ch.stream_end = 1'b0;
        final_err         = jsu_pkg::ErrNone;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // whitespace, byte extremes and every simple escape at the reset bound
        send_raw(ChSpace, 1'b0);
        send_raw(ChTab, 1'b0);
        send_raw(ChCr, 1'b0);
        send_raw(ChLf, 1'b0);
        send_raw(ChQuote, 1'b0);
        send_raw(8'h00, 1'b0);
        send_raw(8'hFF, 1'b0);
        for (k = 0; k < 8; k++) begin
            send_raw(ChBslash, 1'b0);
            send_raw(esc_letter(k), 1'b0);
        end
        send_raw(ChQuote, 1'b0);

        run_strings(70);
        cfg_write(16'hFFFF);
        run_strings(125);
        cfg_write(16'd1);
        run_strings(155);
        // zero bound: only empty strings get through
        cfg_write(16'd0);
        run_strings(170);
        cfg_write(16'($urandom_range(2, 40)));
        run_strings(215);
        send_failure();
        end_burst();

        do @(negedge clk); while (words_pending != 0);
        repeat (10) @(posedge clk);

        $display("covered %0d input bytes, %0d decoded words compared, %0d bound writes",
                 bytes_sent, words_checked, reg_writes);
        $display("stream closed with error code %0d under a bound of %0d",
                 final_err, max_len_now);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/jsu_pkg.sv
rtl/jsu_if.sv
rtl/jsu_front.sv
rtl/jsu_fifo.sv
rtl/jsu_back.sv
rtl/json_string_unescape.sv
tb/sv/json_string_unescape_checker.sv
tb/sv/json_string_unescape_test.sv
